// ===== src/phre_pkg.sv =====
// shared types, constants and codes of the peak hold and release envelope
package phre_pkg;

    localparam int MAX_HOLD_DEF    = 255;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int HOLD_W          = 8;
    localparam int REL_W           = 16;
    localparam int RCNT_W          = 24;
    localparam int CFG_IDX_W       = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLD_LENGTH    = 2'd0,
        REG_RELEASE_LENGTH = 2'd1,
        REG_UPPER_LIMIT    = 2'd2,
        REG_LOWER_LIMIT    = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_H_RD,
        OP_H_EXP,
        OP_H_TRD,
        OP_H_POP,
        OP_H_PUSH,
        OP_H_HRD,
        OP_H_HGET,
        OP_R_CHK,
        OP_R_MUL,
        OP_DIV_GO,
        OP_R_LINE,
        OP_LOAD_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic side;
    } t_cmd;

    typedef struct packed {
        logic bypass;
        logic cnt_zero;
        logic tail_pop;
        logic same;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ===== src/phre_div.sv =====
// serial restoring divider for unsigned magnitudes, one quotient bit a cycle
module phre_div import phre_pkg::*; #(
    parameter int DIVIDEND_W = 40,
    parameter int DIVISOR_W  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W:0]    w_trial;
    logic                  w_ge;

    assign w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DIVIDEND_W);
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem  <= w_ge ? DIVISOR_W'(w_trial - {1'b0, r_div}) : DIVISOR_W'(w_trial);
                r_quo  <= {r_quo[DIVIDEND_W-2:0], w_ge};
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== src/phre_dp.sv =====
// datapath: settings, delay lines, candidate deques, release arithmetic, output beat
module phre_dp import phre_pkg::*; #(
    parameter int MAX_HOLD    = MAX_HOLD_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TDATA_W     = 32,
    parameter int CFG_W       = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic [TDATA_W-1:0]   i_in_data,
    input  logic                 i_out_ready,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic                 o_out_valid,
    output logic [TDATA_W-1:0]   o_out_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int DEPTH = MAX_HOLD + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int PW    = SB + RCNT_W;
    localparam int LW    = SB + RCNT_W + 1;
    localparam int MW    = SB + RCNT_W + 2;

    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] c);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(c);
        if (s >= (CW+1)'(DEPTH))
            s = s - (CW+1)'(DEPTH);
        return AW'(s);
    endfunction

    logic [HOLD_W-1:0]       r_hold_len;
    logic [REL_W-1:0]        r_rel_len;
    logic signed [SB-1:0]    r_upper;
    logic signed [SB-1:0]    r_lower;

    logic [AW-1:0]           r_pos;
    logic                    r_wrapped;
    logic [AW-1:0]           r_head [2];
    logic [CW-1:0]           r_cnt  [2];
    logic signed [SB-1:0]    r_x    [2];
    logic signed [SB-1:0]    r_held [2];
    logic [RCNT_W-1:0]       r_rcnt [2];
    logic signed [SB-1:0]    r_res  [2];
    logic                    r_neg;
    logic [PW-1:0]           r_mag;
    logic                    r_out_valid;
    logic [TDATA_W-1:0]      r_out_data;

    logic [SB-1:0]           cand_mem [2**(AW+1)];
    logic [SB-1:0]           line_mem [2**(AW+1)];
    logic signed [SB-1:0]    r_rd_cand;
    logic signed [SB-1:0]    r_rd_line;

    logic                    w_side;
    logic [AW-1:0]           w_last;
    logic [AW-1:0]           w_cand_ra;
    logic                    w_cand_re;
    logic [AW-1:0]           w_push_head;
    logic [CW-1:0]           w_push_cnt;
    logic signed [SB-1:0]    w_limit;
    logic signed [SB:0]      w_diff;
    logic signed [MW-1:0]    w_prod;
    logic [PW-1:0]           w_quot;
    logic                    w_div_done;
    logic [REL_W-1:0]        w_divisor;
    logic signed [LW-1:0]    w_line;
    logic                    w_cross;
    logic signed [SB-1:0]    w_sat;

    assign w_side  = i_cmd.side;
    assign w_last  = (int'(r_hold_len) > MAX_HOLD) ? AW'(MAX_HOLD) : AW'(r_hold_len);
    assign w_limit = w_side ? r_upper : r_lower;

    // a full deque drops its oldest candidate before the push
    always_comb begin
        w_push_head = r_head[w_side];
        w_push_cnt  = r_cnt[w_side];
        if (r_cnt[w_side] >= CW'(DEPTH)) begin
            w_push_head = wrap_add(r_head[w_side], CW'(1));
            w_push_cnt  = CW'(DEPTH - 1);
        end
    end

    always_comb begin
        w_cand_re = 1'b1;
        w_cand_ra = r_head[w_side];
        unique case (i_cmd.op)
            OP_H_TRD: w_cand_ra = wrap_add(r_head[w_side], r_cnt[w_side] - CW'(1));
            OP_H_RD, OP_H_HRD: w_cand_ra = r_head[w_side];
            default: w_cand_re = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_cand_re)
            r_rd_cand <= cand_mem[{w_side, w_cand_ra}];
        if (i_cmd.op == OP_H_PUSH)
            cand_mem[{w_side, wrap_add(w_push_head, w_push_cnt)}] <= r_x[w_side];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_H_RD)
            r_rd_line <= line_mem[{w_side, r_pos}];
        if (i_cmd.op == OP_H_PUSH)
            line_mem[{w_side, r_pos}] <= r_x[w_side];
    end

    assign w_diff    = (SB+1)'(w_limit) - (SB+1)'(r_held[w_side]);
    assign w_prod    = MW'(w_diff) * MW'($signed({1'b0, r_rcnt[w_side]}));
    assign w_divisor = (r_rel_len == '0) ? REL_W'(1) : r_rel_len;
    assign w_line    = LW'(r_held[w_side]) + (r_neg ? -$signed({1'b0, w_quot})
                                                    :  $signed({1'b0, w_quot}));
    assign w_cross   = w_side ? (LW'(r_x[w_side]) <= w_line) : (LW'(r_x[w_side]) >= w_line);

    always_comb begin
        if (w_line > LW'(S_MAX))
            w_sat = S_MAX;
        else if (w_line < LW'(S_MIN))
            w_sat = S_MIN;
        else
            w_sat = SB'(w_line);
    end

    phre_div #(
        .DIVIDEND_W (PW),
        .DIVISOR_W  (REL_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == OP_DIV_GO),
        .i_dividend (r_mag),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_len  <= '0;
            r_rel_len   <= REL_W'(1);
            r_upper     <= S_MAX;
            r_lower     <= S_MIN;
            r_pos       <= '0;
            r_wrapped   <= 1'b0;
            r_head      <= '{default: '0};
            r_cnt       <= '{default: '0};
            r_held      <= '{default: '0};
            r_rcnt      <= '{default: '0};
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && i_cmd.op != OP_LOAD_OUT)
                r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_addr))
                    REG_HOLD_LENGTH: begin
                        r_hold_len <= HOLD_W'(i_cfg_wdata);
                        r_pos      <= '0;
                        r_wrapped  <= 1'b0;
                        r_head     <= '{default: '0};
                        r_cnt      <= '{default: '0};
                    end
                    REG_RELEASE_LENGTH: r_rel_len <= REL_W'(i_cfg_wdata);
                    REG_UPPER_LIMIT:    r_upper   <= SB'(i_cfg_wdata);
                    REG_LOWER_LIMIT:    r_lower   <= SB'(i_cfg_wdata);
                endcase
            end
            unique case (i_cmd.op)
                OP_ACCEPT: begin
                    r_x[0] <= i_in_data[SB-1:0];
                    r_x[1] <= i_in_data[2*SB-1:SB];
                end
                OP_H_EXP: begin
                    if (r_wrapped && r_cnt[w_side] != '0 && r_rd_cand == r_rd_line) begin
                        r_head[w_side] <= wrap_add(r_head[w_side], CW'(1));
                        r_cnt[w_side]  <= r_cnt[w_side] - CW'(1);
                    end
                end
                OP_H_POP: begin
                    if (o_sts.tail_pop)
                        r_cnt[w_side] <= r_cnt[w_side] - CW'(1);
                end
                OP_H_PUSH: begin
                    r_head[w_side] <= w_push_head;
                    r_cnt[w_side]  <= w_push_cnt + CW'(1);
                end
                OP_H_HGET: begin
                    r_x[w_side] <= r_rd_cand;
                    if (w_side) begin
                        if (r_pos == w_last) begin
                            r_pos     <= '0;
                            r_wrapped <= 1'b1;
                        end else begin
                            r_pos <= r_pos + AW'(1);
                        end
                    end
                end
                OP_R_CHK: begin
                    if (o_sts.same) begin
                        r_rcnt[w_side] <= '0;
                        r_res[w_side]  <= r_x[w_side];
                    end else if (r_rcnt[w_side] != '1) begin
                        r_rcnt[w_side] <= r_rcnt[w_side] + RCNT_W'(1);
                    end
                end
                OP_R_MUL: begin
                    r_neg <= w_prod[MW-1];
                    r_mag <= PW'(w_prod[MW-1] ? -w_prod : w_prod);
                end
                OP_R_LINE: begin
                    if (w_cross) begin
                        r_held[w_side] <= r_x[w_side];
                        r_rcnt[w_side] <= '0;
                        r_res[w_side]  <= r_x[w_side];
                    end else begin
                        r_res[w_side] <= w_sat;
                    end
                end
                OP_LOAD_OUT: begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= TDATA_W'({r_res[1], r_res[0]});
                end
                default: ;
            endcase
        end
    end

    assign o_sts.bypass   = (r_hold_len == '0);
    assign o_sts.cnt_zero = (r_cnt[w_side] == '0);
    assign o_sts.tail_pop = w_side ? (r_rd_cand > r_x[w_side]) : (r_rd_cand < r_x[w_side]);
    assign o_sts.same     = (r_held[w_side] == r_x[w_side]);
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== src/phre_ctrl.sv =====
// controller: sequences hold, release and output steps for one beat
module phre_ctrl import phre_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_H_RD, S_H_EXP, S_H_TRD, S_H_TCMP, S_H_PUSH, S_H_HRD, S_H_HGET,
        S_R_CHK, S_R_MUL, S_R_DGO, S_R_DIV, S_R_LINE, S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_side;
    logic   n_side;

    always_comb begin
        n_state    = r_state;
        n_side     = r_side;
        o_cmd.op   = OP_NONE;
        o_cmd.side = r_side;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    n_side   = 1'b0;
                    n_state  = i_sts.bypass ? S_R_CHK : S_H_RD;
                end
            end
            S_H_RD: begin
                o_cmd.op = OP_H_RD;
                n_state  = S_H_EXP;
            end
            S_H_EXP: begin
                o_cmd.op = OP_H_EXP;
                n_state  = S_H_TRD;
            end
            S_H_TRD: begin
                if (i_sts.cnt_zero) begin
                    n_state = S_H_PUSH;
                end else begin
                    o_cmd.op = OP_H_TRD;
                    n_state  = S_H_TCMP;
                end
            end
            S_H_TCMP: begin
                o_cmd.op = OP_H_POP;
                n_state  = i_sts.tail_pop ? S_H_TRD : S_H_PUSH;
            end
            S_H_PUSH: begin
                o_cmd.op = OP_H_PUSH;
                n_state  = S_H_HRD;
            end
            S_H_HRD: begin
                o_cmd.op = OP_H_HRD;
                n_state  = S_H_HGET;
            end
            S_H_HGET: begin
                o_cmd.op = OP_H_HGET;
                n_side   = !r_side;
                n_state  = r_side ? S_R_CHK : S_H_RD;
            end
            S_R_CHK: begin
                o_cmd.op = OP_R_CHK;
                if (i_sts.same) begin
                    n_side  = !r_side;
                    n_state = r_side ? S_OUT : S_R_CHK;
                end else begin
                    n_state = S_R_MUL;
                end
            end
            S_R_MUL: begin
                o_cmd.op = OP_R_MUL;
                n_state  = S_R_DGO;
            end
            S_R_DGO: begin
                o_cmd.op = OP_DIV_GO;
                n_state  = S_R_DIV;
            end
            S_R_DIV: begin
                if (i_sts.div_done)
                    n_state = S_R_LINE;
            end
            S_R_LINE: begin
                o_cmd.op = OP_R_LINE;
                n_side   = !r_side;
                n_state  = r_side ? S_OUT : S_R_CHK;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_LOAD_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_side  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_side  <= n_side;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== src/peak_hold_release_envelope.sv =====
// top level: peak hold over a sliding window with linear release of both envelopes
// per side, the hold stage reads, expires, pops the tail while it loses, pushes and reads the head;
//   then per side the release is skipped if the sample equals the held value, else it multiplies
//   and runs the serial divider; then the output beat is loaded, waiting while the last one is pending
// one beat at a time: a new sample pair is taken only once the previous beat is loaded out
// reset: synchronous active low; settings to defaults, hold stores and release state empty
module peak_hold_release_envelope import phre_pkg::*; #(
    parameter int MAX_HOLD    = MAX_HOLD_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [((SAMPLE_BITS > REL_W) ? SAMPLE_BITS : REL_W)-1:0] i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // top_sample, bottom_sample
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // top_envelope, bottom_envelope
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);

    localparam int TDATA_W = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int CFG_W   = (SAMPLE_BITS > REL_W) ? SAMPLE_BITS : REL_W;

    t_cmd w_cmd;
    t_sts w_sts;

    phre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    phre_dp #(
        .MAX_HOLD    (MAX_HOLD),
        .SAMPLE_BITS (SAMPLE_BITS),
        .TDATA_W     (TDATA_W),
        .CFG_W       (CFG_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a beat is in flight");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.op == OP_LOAD_OUT |-> !m_axis_tvalid || m_axis_tready)
        else $error("pending output beat overwritten");

    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.op == OP_LOAD_OUT))
        else $error("output beat without load");

endmodule

// ===== tb/peak_hold_release_envelope_test.sv =====
// testbench: peak hold envelope with linear release, checked beat by beat against a local predictor
module peak_hold_release_envelope_test import phre_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MH = 255;
    localparam int DEP = MH + 1;
    localparam int CMAX = 24'hFFFFFF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // top_sample, bottom_sample
    logic [31:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // top_envelope, bottom_envelope
    logic [31:0] m_axis_tdata;

    peak_hold_release_envelope uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    int unsigned hold_len, rel_len;
    longint upper_lim, lower_lim;
    bit line_full[2][DEP];
    longint line_val[2][DEP];
    longint cands[2][DEP];
    int unsigned c_head[2], c_cnt[2];
    int unsigned dpos;
    longint held[2];
    int unsigned rcnt[2];

    logic [31:0] envelope_q[2048];
    int env_wr = 0, env_rd = 0;
    int errors = 0;
    int beats_in = 0, beats_out = 0;
    int send_idle = 0, recv_idle = 0;

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("error: %s got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void clear_hold();
        for (int s = 0; s < 2; s++) begin
            for (int k = 0; k < DEP; k++) line_full[s][k] = 0;
            c_head[s] = 0;
            c_cnt[s] = 0;
        end
        dpos = 0;
    endfunction

    function automatic longint hold_side(int s, longint x, int unsigned pos);
        longint b;
        if (line_full[s][pos] && c_cnt[s] > 0 && cands[s][c_head[s]] == line_val[s][pos]) begin
            c_head[s] = (c_head[s] + 1) % DEP;
            c_cnt[s]--;
        end
        while (c_cnt[s] > 0) begin
            b = cands[s][(c_head[s] + c_cnt[s] - 1) % DEP];
            if (s == 0 ? (b < x) : (b > x)) c_cnt[s]--;
            else break;
        end
        if (c_cnt[s] >= DEP) begin
            c_head[s] = (c_head[s] + 1) % DEP;
            c_cnt[s] = DEP - 1;
        end
        cands[s][(c_head[s] + c_cnt[s]) % DEP] = x;
        c_cnt[s]++;
        line_full[s][pos] = 1;
        line_val[s][pos] = x;
        return cands[s][c_head[s]];
    endfunction

    function automatic longint release_side(int s, longint x, longint target);
        longint rel, ln;
        if (held[s] == x) begin
            rcnt[s] = 0;
            return x;
        end
        if (rcnt[s] < CMAX) rcnt[s]++;
        rel = rel_len ? rel_len : 1;
        ln = held[s] + ((target - held[s]) * longint'(rcnt[s])) / rel;
        if (s == 0 ? (x >= ln) : (x <= ln)) begin
            held[s] = x;
            rcnt[s] = 0;
            return x;
        end
        if (ln > 32767) ln = 32767;
        if (ln < -32768) ln = -32768;
        return ln;
    endfunction

    function automatic logic [31:0] predict_envelope(logic [15:0] ts, logic [15:0] bs);
        longint t, b, ot, ob;
        int unsigned win, pos;
        t = longint'($signed(ts));
        b = longint'($signed(bs));
        if (hold_len != 0) begin
            win = hold_len + 1;
            pos = dpos < win ? dpos : 0;
            t = hold_side(0, t, pos);
            b = hold_side(1, b, pos);
            dpos = (pos + 1 >= win) ? 0 : pos + 1;
        end
        ot = release_side(0, t, lower_lim);
        ob = release_side(1, b, upper_lim);
        return {ob[15:0], ot[15:0]};
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [15:0] v);
        while (env_wr != env_rd) @(posedge i_clk);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_HOLD_LENGTH: begin
                hold_len = v[7:0];
                clear_hold();
            end
            REG_RELEASE_LENGTH: rel_len = v;
            REG_UPPER_LIMIT: upper_lim = longint'($signed(v));
            REG_LOWER_LIMIT: lower_lim = longint'($signed(v));
            default: ;
        endcase
    endtask

    task automatic send_pair(logic [15:0] ts, logic [15:0] bs);
        do @(posedge i_clk); while (send_idle > 0 && $urandom_range(99) < send_idle);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {bs, ts};
        envelope_q[env_wr % 2048] = predict_envelope(ts, bs);
        env_wr++;
        do @(posedge i_clk); while (!s_axis_tready);
        beats_in++;
        s_axis_tvalid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            beats_out++;
            if (env_wr == env_rd) begin
                report("unexpected beat", m_axis_tdata, '0);
            end else begin
                logic [31:0] w;
                w = envelope_q[env_rd % 2048];
                env_rd++;
                if (m_axis_tdata[15:0] !== w[15:0])
                    report("top_envelope", m_axis_tdata[15:0], w[15:0]);
                if (m_axis_tdata[31:16] !== w[31:16])
                    report("bottom_envelope", m_axis_tdata[31:16], w[31:16]);
            end
        end
        m_axis_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    end

    task automatic drain();
        while (env_wr != env_rd) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(40)) - 16'd20;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [15:0] ext[6] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA};
        foreach (ext[k]) send_pair(ext[k], ext[5 - k]);
        write_reg(REG_RELEASE_LENGTH, 16'd4);
        send_pair(16'h1000, 16'hF000);
        repeat (6) send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h2000, 16'hE000);
        write_reg(REG_RELEASE_LENGTH, 16'd0);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'h0100, 16'h0100);
        drain();
        write_reg(REG_HOLD_LENGTH, 16'd3);
        write_reg(REG_RELEASE_LENGTH, 16'd3);
        foreach (ext[k]) send_pair(ext[k], ext[k]);
        send_pair(16'h0010, 16'h0010);
        drain();
    endtask

    task automatic test_setting(int unsigned h, int unsigned r, logic [15:0] up,
                                logic [15:0] lo, int n);
        write_reg(REG_HOLD_LENGTH, 16'(h));
        write_reg(REG_RELEASE_LENGTH, 16'(r));
        write_reg(REG_UPPER_LIMIT, up);
        write_reg(REG_LOWER_LIMIT, lo);
        repeat (n) send_pair(rand_sample(), rand_sample());
        drain();
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n / 50; k++)
            test_setting($urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(8),
                         $urandom_range(3) == 0 ? $urandom : $urandom_range(1, 20),
                         16'($urandom), 16'($urandom), 50);
    endtask

    initial begin
        hold_len = 0;
        rel_len = 1;
        upper_lim = 32767;
        lower_lim = -32768;
        clear_hold();
        held = '{0, 0};
        rcnt = '{0, 0};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle = 9;
        recv_idle = 45;
        test_directed();
        test_setting(255, 65535, 16'h7FFF, 16'h8000, 300);
        test_setting(0, 1, 16'h8000, 16'h7FFF, 50);
        test_setting(1, 2, 16'h0000, 16'h0000, 50);
        test_random(350);
        send_idle = 45;
        recv_idle = 9;
        test_random(400);
        send_idle = 0;
        recv_idle = 0;
        test_random(350);
        $display("covered %0d sample pairs in, %0d envelope beats out", beats_in, beats_out);
        $display("hold lengths 0 to 255, release 0 to 65535, full range limits");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("timeout");
        $display("Mismatches found");
        $finish;
    end
endmodule
